FILE: rtl/bbms_pkg.sv
// Shared types and constants for the bounding box match selector.
package bbms_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_ADDR_BITS  = 3;

    // Reset values of the configuration registers
    localparam int REF_X_RST   = 320;
    localparam int REF_Y_RST   = 240;
    localparam int REF_W_RST   = 0;
    localparam int REF_H_RST   = 0;
    localparam int NEAR_RST    = 50;
    localparam int PERFECT_RST = 3;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_REF_X   = 3'd0,
        CFG_REF_Y   = 3'd1,
        CFG_REF_W   = 3'd2,
        CFG_REF_H   = 3'd3,
        CFG_NEAR    = 3'd4,
        CFG_PERFECT = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic load;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last;
        logic out_full;
    } dp_status_t;

endpackage

FILE: rtl/bbms_div.sv
// Serial restoring divider for a min/max ratio in unsigned Q1.FRAC.
module bbms_div
    import bbms_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] a,
    input  logic [COORD_BITS-1:0] b,
    output logic                  busy,
    output logic [FRAC_BITS:0]    quo
);

    localparam int CNT_BITS = $clog2(FRAC_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS - 1);

    logic                  busy_reg, busy_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [COORD_BITS-1:0] hi_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [FRAC_BITS-1:0]  q_reg;
    logic                  eq_reg;
    logic                  zero_reg;

    logic [COORD_BITS-1:0] lo_in, hi_in;
    logic [COORD_BITS:0]   rem_sh;
    logic                  take;

    always_comb
    begin
        lo_in  = (a < b) ? a : b;
        hi_in  = (a < b) ? b : a;
        rem_sh = {rem_reg, 1'b0};
        take   = (rem_sh >= {1'b0, hi_reg});
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && (cnt_reg == CNT_LAST))
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg  <= '0;
            hi_reg   <= hi_in;
            rem_reg  <= lo_in;
            q_reg    <= '0;
            eq_reg   <= (lo_in == hi_in);
            zero_reg <= (hi_in == '0);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            q_reg   <= {q_reg[FRAC_BITS-2:0], take};
            if (take)
            begin
                rem_reg <= COORD_BITS'(rem_sh - {1'b0, hi_reg});
            end
            else
            begin
                rem_reg <= rem_sh[COORD_BITS-1:0];
            end
        end
    end

    // Equal sides give exactly one, unless both are zero
    always_comb
    begin
        if (zero_reg)
        begin
            quo = '0;
        end
        else if (eq_reg)
        begin
            quo = {1'b1, {FRAC_BITS{1'b0}}};
        end
        else
        begin
            quo = {1'b0, q_reg};
        end
    end

    assign busy = busy_reg;

endmodule

FILE: rtl/bbms_dp.sv
// Datapath: config registers, distance test, ratio dividers, best box and result register.
module bbms_dp
    import bbms_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COORD_BITS-1:0]    cfg_wdata,
    input  logic [COORD_BITS-1:0]    box_left,
    input  logic [COORD_BITS-1:0]    box_top,
    input  logic [COORD_BITS-1:0]    box_width,
    input  logic [COORD_BITS-1:0]    box_height,
    input  logic                     frame_end,
    input  ctrl_cmd_t                cmd,
    output dp_status_t               status,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic                     match_found,
    output logic [COORD_BITS-1:0]    best_left,
    output logic [COORD_BITS-1:0]    best_top,
    output logic [COORD_BITS-1:0]    best_width,
    output logic [COORD_BITS-1:0]    best_height,
    output logic [FRAC_BITS:0]       best_score
);

    localparam int C  = COORD_BITS;
    localparam int SB = FRAC_BITS + 1;
    localparam logic [SB-1:0] SCORE_ONE   = SB'(1) << FRAC_BITS;
    localparam logic [SB-1:0] SCORE_FLOOR = SB'(3) << (FRAC_BITS - 2);

    // Configuration registers
    logic [C-1:0] ref_x_reg, ref_y_reg, ref_w_reg, ref_h_reg, near_reg, perf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= C'(REF_X_RST);
            ref_y_reg <= C'(REF_Y_RST);
            ref_w_reg <= C'(REF_W_RST);
            ref_h_reg <= C'(REF_H_RST);
            near_reg  <= C'(NEAR_RST);
            perf_reg  <= C'(PERFECT_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_REF_X:   ref_x_reg <= cfg_wdata;
                CFG_REF_Y:   ref_y_reg <= cfg_wdata;
                CFG_REF_W:   ref_w_reg <= cfg_wdata;
                CFG_REF_H:   ref_h_reg <= cfg_wdata;
                CFG_NEAR:    near_reg  <= cfg_wdata;
                CFG_PERFECT: perf_reg  <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Candidate capture and centre offsets
    logic [C-1:0] x_reg, y_reg, w_reg, h_reg;
    logic         last_reg;
    logic [C:0]   cx, cy, dx_next, dy_next, dx_reg, dy_reg;

    always_comb
    begin
        cx = {1'b0, box_left} + {2'b00, box_width[C-1:1]};
        cy = {1'b0, box_top} + {2'b00, box_height[C-1:1]};
        dx_next = (cx >= {1'b0, ref_x_reg}) ? cx - {1'b0, ref_x_reg}
                                            : {1'b0, ref_x_reg} - cx;
        dy_next = (cy >= {1'b0, ref_y_reg}) ? cy - {1'b0, ref_y_reg}
                                            : {1'b0, ref_y_reg} - cy;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= box_left;
            y_reg    <= box_top;
            w_reg    <= box_width;
            h_reg    <= box_height;
            last_reg <= frame_end;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
        end
    end

    // Squared distance against squared limits: isqrt(d) > L iff d >= (L+1)^2,
    // isqrt(d) < P iff d < P^2
    logic [2*C+1:0] dx2_reg, dy2_reg, lim2_reg, per2_reg;
    logic [C:0]     near_p1;
    logic [2*C+2:0] dist2;
    logic           far_reg, close_reg;

    assign near_p1 = {1'b0, near_reg} + 1'b1;

    always_ff @(posedge clk)
    begin
        dx2_reg  <= {{(C+1){1'b0}}, dx_reg} * {{(C+1){1'b0}}, dx_reg};
        dy2_reg  <= {{(C+1){1'b0}}, dy_reg} * {{(C+1){1'b0}}, dy_reg};
        lim2_reg <= {{(C+1){1'b0}}, near_p1} * {{(C+1){1'b0}}, near_p1};
        per2_reg <= {{(C+2){1'b0}}, perf_reg} * {{(C+2){1'b0}}, perf_reg};
    end

    assign dist2 = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    always_ff @(posedge clk)
    begin
        far_reg   <= (dist2 >= {1'b0, lim2_reg});
        close_reg <= (dist2 < {1'b0, per2_reg});
    end

    // Ratio dividers, run side by side
    logic          busy_h, busy_w;
    logic [SB-1:0] ratio_h, ratio_w;

    bbms_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_h (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .a     (box_height),
        .b     (ref_h_reg),
        .busy  (busy_h),
        .quo   (ratio_h)
    );

    bbms_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_w (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .a     (box_width),
        .b     (ref_w_reg),
        .busy  (busy_w),
        .quo   (ratio_w)
    );

    logic [SB:0]   ratio_sum;
    logic [SB-1:0] score;

    always_comb
    begin
        ratio_sum = {1'b0, ratio_h} + {1'b0, ratio_w};
        if (far_reg)
        begin
            score = '0;
        end
        else if (close_reg)
        begin
            score = SCORE_ONE;
        end
        else
        begin
            score = ratio_sum[SB:1];
        end
    end

    // Best-so-far tracking
    logic [SB-1:0] top_score_reg, top_score_next;
    logic [C-1:0]  tx_reg, ty_reg, tw_reg, th_reg;
    logic [C-1:0]  tx_next, ty_next, tw_next, th_next;
    logic          have_reg, have_next, perfect_reg, perfect_next;
    logic          win;
    logic          out_valid_reg;

    always_comb
    begin
        win            = !perfect_reg && (score > top_score_reg);
        top_score_next = top_score_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        tw_next        = tw_reg;
        th_next        = th_reg;
        have_next      = have_reg;
        perfect_next   = perfect_reg;
        if (win)
        begin
            top_score_next = score;
            tx_next        = x_reg;
            ty_next        = y_reg;
            tw_next        = w_reg;
            th_next        = h_reg;
            have_next      = 1'b1;
            perfect_next   = (score == SCORE_ONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_score_reg <= SCORE_FLOOR;
            tx_reg        <= '0;
            ty_reg        <= '0;
            tw_reg        <= '0;
            th_reg        <= '0;
            have_reg      <= 1'b0;
            perfect_reg   <= 1'b0;
        end
        else if (cmd.update)
        begin
            if (last_reg)
            begin
                // clear for the next frame
                top_score_reg <= SCORE_FLOOR;
                tx_reg        <= '0;
                ty_reg        <= '0;
                tw_reg        <= '0;
                th_reg        <= '0;
                have_reg      <= 1'b0;
                perfect_reg   <= 1'b0;
            end
            else
            begin
                top_score_reg <= top_score_next;
                tx_reg        <= tx_next;
                ty_reg        <= ty_next;
                tw_reg        <= tw_next;
                th_reg        <= th_next;
                have_reg      <= have_next;
                perfect_reg   <= perfect_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && last_reg)
        begin
            match_found <= have_next;
            best_left   <= have_next ? tx_next : '0;
            best_top    <= have_next ? ty_next : '0;
            best_width  <= have_next ? tw_next : '0;
            best_height <= have_next ? th_next : '0;
            best_score  <= have_next ? top_score_next : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.div_done = !busy_h && !busy_w;
    assign status.last     = last_reg;
    assign status.out_full = out_valid_reg && !out_ready;

endmodule

FILE: rtl/bbms_ctrl.sv
// Controller: sequences accept, ratio division and best-box update.
module bbms_ctrl
    import bbms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                // hold a frame's last beat until the result register is free
                if (!(status.last && status.out_full))
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/bounding_box_match_selector_top.sv
// A candidate is accepted in ST_IDLE; ST_DIV waits for the two bit-serial ratio dividers,
// which run side by side, then ST_UPD updates the best box and, on a frame's last beat,
// sets the result register and m_tvalid. No new candidate is taken before that update.
// A waiting result stalls only the update of a later frame's last beat.
// Reset (rst_n, async, active low) loads register defaults and clears the best box.
module bounding_box_match_selector_top
    import bbms_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_BITS   = 4 * COORD_BITS,
    localparam int IN_BYTES  = (IN_BITS + 7) / 8,
    localparam int OUT_BITS  = 4 * COORD_BITS + FRAC_BITS + 1,
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COORD_BITS-1:0]    cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // box_left, box_top, box_width, box_height
    input  logic [8*IN_BYTES-1:0]    s_tdata,
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // best_left, best_top, best_width, best_height, best_score, zero fill
    output logic [8*OUT_BYTES-1:0]   m_tdata,
    // match_found
    output logic                     m_tuser
);

    localparam int C = COORD_BITS;

    ctrl_cmd_t             cmd;
    dp_status_t            status;
    logic [C-1:0]          best_left, best_top, best_width, best_height;
    logic [FRAC_BITS:0]    best_score;

    bbms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bbms_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .box_left    (s_tdata[C-1:0]),
        .box_top     (s_tdata[2*C-1:C]),
        .box_width   (s_tdata[3*C-1:2*C]),
        .box_height  (s_tdata[4*C-1:3*C]),
        .frame_end   (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .match_found (m_tuser),
        .best_left   (best_left),
        .best_top    (best_top),
        .best_width  (best_width),
        .best_height (best_height),
        .best_score  (best_score)
    );

    assign m_tdata = (8*OUT_BYTES)'({best_score, best_height, best_width, best_top, best_left});

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the bounding box match selector: directed and random frames.
module tb_top;
    import bbms_pkg::*;

    localparam int CW        = COORD_BITS_DEF;
    localparam int FW        = FRAC_BITS_DEF;
    localparam int COORD_MAX = (1 << CW) - 1;
    localparam int IN_W      = 8 * ((4 * CW + 7) / 8);
    localparam int OUT_W     = 8 * ((4 * CW + FW + 1 + 7) / 8);
    localparam int LATENCY   = FW + 3;
    localparam int STUCK_MAX = 5000;
    localparam logic [FW:0] SCORE_ONE   = (FW+1)'(1 << FW);
    localparam logic [FW:0] SCORE_FLOOR = (FW+1)'(3 << (FW - 2));

    // first member sits in the top bits, so box_left lands in bit 0
    typedef struct packed {
        logic [CW-1:0] height;
        logic [CW-1:0] width;
        logic [CW-1:0] top;
        logic [CW-1:0] left;
    } box_t;

    typedef struct {
        logic        found;
        box_t        box;
        logic [FW:0] score;
    } winner_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = CFG_REF_X;
    logic [CW-1:0]            cfg_wdata = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_W-1:0]          s_tdata = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_W-1:0]         m_tdata;
    logic                     m_tuser;

    bounding_box_match_selector_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // reference registers as seen by the selector
    int unsigned ref_x, ref_y, ref_w, ref_h, near_lim, perf_rad;
    // running best of the current frame
    logic [FW:0] best_score;
    box_t        best_box;
    logic        found;
    logic        perfect_hit;

    winner_t expected_winners[$];

    int  errors;
    int  boxes_sent;
    int  frames_checked;
    int  matches_seen;
    int  perfect_frames;
    bit  calm;
    int  stall_left;
    int  stuck_cycles;

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned side_ratio(longint unsigned a, longint unsigned b);
        longint unsigned lo;
        longint unsigned hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (hi == 0)
            return 0;
        return (lo << FW) / hi;
    endfunction

    function automatic logic [FW:0] score_candidate(box_t b);
        longint dx;
        longint dy;
        longint unsigned centre_gap;
        dx = longint'(b.left) + longint'(b.width >> 1) - longint'(ref_x);
        dy = longint'(b.top) + longint'(b.height >> 1) - longint'(ref_y);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        centre_gap = int_root(dx * dx + dy * dy);
        if (centre_gap > near_lim)
            return '0;
        if (centre_gap < perf_rad)
            return SCORE_ONE;
        return (FW+1)'((side_ratio(b.height, ref_h) + side_ratio(b.width, ref_w)) >> 1);
    endfunction

    function automatic void clear_frame();
        best_score  = SCORE_FLOOR;
        best_box    = '0;
        found       = 1'b0;
        perfect_hit = 1'b0;
    endfunction

    function automatic void select_candidate(box_t b, bit last);
        logic [FW:0] s;
        winner_t     w;
        if (!perfect_hit)
        begin
            s = score_candidate(b);
            if (s > best_score)
            begin
                best_score = s;
                best_box   = b;
                found      = 1'b1;
            end
            if (best_score == SCORE_ONE)
                perfect_hit = 1'b1;
        end
        if (last)
        begin
            w.found = found;
            w.box   = found ? best_box : '0;
            w.score = found ? best_score : '0;
            expected_winners.push_back(w);
            clear_frame();
        end
    endfunction

    function automatic int pick_pause();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch in frame %0d, %s: got %0d, expected %0d",
                 frames_checked, what, got, want);
    endtask

    task automatic send_box(box_t b, bit last);
        int gap;
        gap = pick_pause();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        // ready is sampled as it stood before the edge
        @(posedge clk iff s_tready);
        select_candidate(b, last);
        boxes_sent++;
    endtask

    task automatic send_coords(int l, int t, int w, int h, bit last);
        box_t b;
        b.left   = CW'(l);
        b.top    = CW'(t);
        b.width  = CW'(w);
        b.height = CW'(h);
        send_box(b, last);
    endtask

    // drop valid, let every winner come out, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_winners.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
    endtask

    task automatic load_refs(int unsigned cx, int unsigned cy, int unsigned w,
                             int unsigned h, int unsigned nl, int unsigned pr);
        cfg_idx_t    order[6];
        int unsigned vals[6];
        order = '{CFG_REF_X, CFG_REF_Y, CFG_REF_W, CFG_REF_H, CFG_NEAR, CFG_PERFECT};
        vals  = '{cx, cy, w, h, nl, pr};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= order[i];
            cfg_wdata <= vals[i][CW-1:0];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        ref_x    = cx & COORD_MAX;
        ref_y    = cy & COORD_MAX;
        ref_w    = w & COORD_MAX;
        ref_h    = h & COORD_MAX;
        near_lim = nl & COORD_MAX;
        perf_rad = pr & COORD_MAX;
    endtask

    function automatic int near_size(int unsigned v);
        if ($urandom_range(0, 3) == 0)
            return v;
        return clamp_coord(int'(v) - int'(v / 4) + int'($urandom_range(0, v / 2 + 1)));
    endfunction

    // mostly boxes close to the reference, the rest anywhere
    function automatic box_t make_candidate();
        box_t b;
        int   w;
        int   h;
        int   span;
        int   cx;
        int   cy;
        if ($urandom_range(0, 99) < 25)
        begin
            b = box_t'({$urandom, $urandom});
            return b;
        end
        w    = near_size(ref_w);
        h    = near_size(ref_h);
        span = (near_lim + 3 > 90) ? 90 : near_lim + 3;
        cx   = int'(ref_x) + int'($urandom_range(0, 2 * span)) - span;
        cy   = int'(ref_y) + int'($urandom_range(0, 2 * span)) - span;
        b.width  = CW'(w);
        b.height = CW'(h);
        b.left   = CW'(clamp_coord(cx - w / 2));
        b.top    = CW'(clamp_coord(cy - h / 2));
        return b;
    endfunction

    task automatic run_frames(int n_items);
        int start;
        int len;
        start = boxes_sent;
        while (boxes_sent - start < n_items)
        begin
            len = $urandom_range(1, 8);
            for (int k = 1; k <= len; k++)
                send_box(make_candidate(), k == len);
        end
    endtask

    task automatic test_default_registers();
        // perfect hit, then the rest of the frame is ignored
        send_coords(318, 238, 4, 4, 0);
        send_coords(319, 239, 2, 2, 0);
        send_coords(0, 0, 0, 0, 1);
        // zero-size box against a zero-size reference scores nothing
        send_coords(330, 240, 0, 0, 0);
        send_coords(325, 235, 10, 10, 1);
        send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
        send_coords(0, 0, 0, 0, 1);
        wait_drained();
    endtask

    task automatic test_ratio_scoring();
        load_refs(512, 512, 200, 100, COORD_MAX, 0);
        // full ratio match counts as perfect
        send_coords(412, 462, 200, 100, 0);
        send_coords(0, 0, 0, 0, 0);
        send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
        // exactly on the floor does not win
        send_coords(462, 462, 100, 100, 0);
        send_coords(412, 412, 200, 200, 0);
        send_coords(422, 462, 180, 100, 0);
        send_coords(417, 462, 190, 100, 0);
        send_coords(432, 462, 160, 100, 0);
        send_coords(512, 512, 0, 0, 1);
        wait_drained();
    endtask

    task automatic test_distance_bounds();
        load_refs(100, 100, 20, 20, 5, 5);
        send_coords(95, 94, 16, 20, 0);   // distance equals the limit and the radius
        send_coords(98, 90, 16, 20, 0);   // one past the limit
        send_coords(96, 92, 16, 20, 1);   // inside the radius
        wait_drained();
    endtask

    task automatic test_random_frames();
        load_refs(0, 0, 0, COORD_MAX, COORD_MAX, 0);
        run_frames(150);
        wait_drained();
        calm = 1'b1;
        load_refs(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, COORD_MAX);
        run_frames(150);
        wait_drained();
        for (int p = 0; p < 10; p++)
        begin
            calm = (p % 3 == 2);
            load_refs($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, 120), $urandom_range(0, 8));
            run_frames(155);
            wait_drained();
        end
        calm = 1'b0;
    endtask

    always @(posedge clk)
    begin : sink_side
        int pause;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            pause = pick_pause();
            m_tready   <= (pause == 0);
            stall_left <= (pause > 0) ? pause - 1 : 0;
        end
    end

    always @(posedge clk)
    begin : winner_check
        winner_t want;
        box_t    got_box;
        if (m_tvalid && m_tready)
        begin
            got_box = m_tdata[4*CW-1:0];
            if (expected_winners.size() == 0)
                report_mismatch("result with none pending", m_tuser, 0);
            else
            begin
                want = expected_winners.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch("match_found", m_tuser, want.found);
                if (got_box.left !== want.box.left)
                    report_mismatch("best_left", got_box.left, want.box.left);
                if (got_box.top !== want.box.top)
                    report_mismatch("best_top", got_box.top, want.box.top);
                if (got_box.width !== want.box.width)
                    report_mismatch("best_width", got_box.width, want.box.width);
                if (got_box.height !== want.box.height)
                    report_mismatch("best_height", got_box.height, want.box.height);
                if (m_tdata[4*CW +: FW+1] !== want.score)
                    report_mismatch("best_score", m_tdata[4*CW +: FW+1], want.score);
                if (want.found)
                    matches_seen++;
                if (want.score == SCORE_ONE)
                    perfect_frames++;
                frames_checked++;
            end
        end
    end

    // end the run when no beat moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_MAX)
        begin
            $display("timeout after %0d cycles without a beat", STUCK_MAX);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        boxes_sent = 0;
        frames_checked = 0;
        matches_seen = 0;
        perfect_frames = 0;
        calm = 1'b0;
        stall_left = 0;
        stuck_cycles = 0;
        ref_x    = REF_X_RST;
        ref_y    = REF_Y_RST;
        ref_w    = REF_W_RST;
        ref_h    = REF_H_RST;
        near_lim = NEAR_RST;
        perf_rad = PERFECT_RST;
        clear_frame();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_registers();
        test_ratio_scoring();
        test_distance_bounds();
        test_random_frames();
        wait_drained();

        $display("sent %0d candidate boxes, checked %0d frame winners", boxes_sent,
                 frames_checked);
        $display("%0d frames had a match, %0d of them perfect; %0d mismatches",
                 matches_seen, perfect_frames, errors);
        if (errors == 0 && expected_winners.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bbms_pkg.sv
rtl/bbms_div.sv
rtl/bbms_dp.sv
rtl/bbms_ctrl.sv
rtl/bounding_box_match_selector_top.sv
test/tb_top.sv
